// File: src/eight_bit_cpu_alu_with_flags_top_assert.svh
// Assertion macros shared by the ALU checker.
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_TOP_ASSERT_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define EBCALU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Implication checked at the same edge.
`define EBCALU_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Implication checked at the next edge.
`define EBCALU_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: src/ebcalu_pkg.sv
// Types and operation codes of the 8-bit CPU ALU.
package ebcalu_pkg;

    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_ADC   = 5'd1;
    localparam logic [4:0] OP_SUB   = 5'd2;
    localparam logic [4:0] OP_SBC   = 5'd3;
    localparam logic [4:0] OP_AND   = 5'd4;
    localparam logic [4:0] OP_XOR   = 5'd5;
    localparam logic [4:0] OP_OR    = 5'd6;
    localparam logic [4:0] OP_CP    = 5'd7;
    localparam logic [4:0] OP_INC   = 5'd8;
    localparam logic [4:0] OP_DEC   = 5'd9;
    localparam logic [4:0] OP_CPL   = 5'd10;
    localparam logic [4:0] OP_RLC   = 5'd11;
    localparam logic [4:0] OP_RRC   = 5'd12;
    localparam logic [4:0] OP_RL    = 5'd13;
    localparam logic [4:0] OP_RR    = 5'd14;
    localparam logic [4:0] OP_SLA   = 5'd15;
    localparam logic [4:0] OP_SRA   = 5'd16;
    localparam logic [4:0] OP_SRL   = 5'd17;
    localparam logic [4:0] OP_RLCA  = 5'd18;
    localparam logic [4:0] OP_RRCA  = 5'd19;
    localparam logic [4:0] OP_RLA   = 5'd20;
    localparam logic [4:0] OP_RRA   = 5'd21;
    localparam logic [4:0] OP_BIT   = 5'd22;
    localparam logic [4:0] OP_RES   = 5'd23;
    localparam logic [4:0] OP_SET   = 5'd24;
    localparam logic [4:0] OP_ADD16 = 5'd25;
    localparam logic [4:0] OP_ADDSP = 5'd26;

    // Flag positions in the flag byte
    localparam int FLAG_Z = 7;
    localparam int FLAG_N = 6;
    localparam int FLAG_H = 5;
    localparam int FLAG_C = 4;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [15:0] target_value;
        logic [15:0] source_value;
        logic [2:0]  bit_index;
        logic [7:0]  flags_in;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [7:0]  flags_out;
    } alu_rsp_t;

endpackage

// File: src/eight_bit_cpu_alu_with_flags_top.sv
// Top level of the 8-bit CPU ALU: input register, ALU logic, result register.
// A request is captured in the input register and its result in the result register.
// Throughput: one request per cycle while m_ready is high; the input and result registers
// form a two-deep pipeline; a request is taken while a result waits if the input is free.
// Reset: synchronous on aresetn low, clears both pipeline valids; payloads keep
// stale data until the next request.
module eight_bit_cpu_alu_with_flags_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ebcalu_pkg::alu_req_t  s_req,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ebcalu_pkg::alu_rsp_t  m_rsp
);

    logic                 in_vld_reg;
    logic                 in_vld_next;
    ebcalu_pkg::alu_req_t in_req_reg;
    ebcalu_pkg::alu_req_t in_req_next;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    ebcalu_pkg::alu_rsp_t out_rsp_reg;
    ebcalu_pkg::alu_rsp_t out_rsp_next;
    ebcalu_pkg::alu_rsp_t core_rsp;
    logic                 out_adv;
    logic                 in_adv;

    ebcalu_core u_core (
        .req (in_req_reg),
        .rsp (core_rsp)
    );

    assign out_adv = !out_vld_reg || m_ready;
    assign in_adv  = !in_vld_reg || out_adv;
    assign s_ready = in_adv;
    assign m_valid = out_vld_reg;
    assign m_rsp   = out_rsp_reg;

    always_comb begin
        in_vld_next  = in_vld_reg;
        in_req_next  = in_req_reg;
        out_vld_next = out_vld_reg;
        out_rsp_next = out_rsp_reg;
        if (in_adv) begin
            in_vld_next = s_valid;
            if (s_valid) begin
                in_req_next = s_req;
            end
        end
        if (out_adv) begin
            out_vld_next = in_vld_reg;
            if (in_vld_reg) begin
                out_rsp_next = core_rsp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_req_reg  <= in_req_next;
        out_rsp_reg <= out_rsp_next;
    end

endmodule

// File: src/ebcalu_core.sv
// Combinational ALU datapath: result value and flag update for one request.
module ebcalu_core (
    input  ebcalu_pkg::alu_req_t req,
    output ebcalu_pkg::alu_rsp_t rsp
);

    logic [7:0]  a;
    logic [7:0]  v;
    logic        cin;
    logic [8:0]  add8;
    logic [4:0]  add4;
    logic [8:0]  sub8;
    logic [4:0]  sub4;
    logic [16:0] add16;
    logic [12:0] add12;
    logic [15:0] sp_sum;
    logic [8:0]  sp_c8;
    logic [4:0]  sp_c4;
    logic        k_add;
    logic        k_sub;

    assign a     = req.target_value[7:0];
    assign v     = req.source_value[7:0];
    assign cin   = req.flags_in[ebcalu_pkg::FLAG_C];
    assign k_add = (req.cmd == ebcalu_pkg::OP_ADC) ? cin : 1'b0;
    assign k_sub = (req.cmd == ebcalu_pkg::OP_SBC) ? cin : 1'b0;

    assign add8  = {1'b0, a} + {1'b0, v} + {8'd0, k_add};
    assign add4  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, k_add};
    // borrow shows in the top bit of the widened difference
    assign sub8  = {1'b0, a} - {1'b0, v} - {8'd0, k_sub};
    assign sub4  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, k_sub};
    assign add16 = {1'b0, req.target_value} + {1'b0, req.source_value};
    assign add12 = {1'b0, req.target_value[11:0]} + {1'b0, req.source_value[11:0]};
    assign sp_sum = req.target_value + {{8{v[7]}}, v};
    assign sp_c8 = {1'b0, req.target_value[7:0]} + {1'b0, v};
    assign sp_c4 = {1'b0, req.target_value[3:0]} + {1'b0, v[3:0]};

    always_comb begin
        logic [15:0] r;
        logic [7:0]  r8;
        logic        z, n, h, c;
        logic        z_calc;
        logic [3:0]  wr;   // Z N H C write enables
        logic [7:0]  f;

        r8     = a;
        r      = 16'd0;
        z      = 1'b0;
        n      = 1'b0;
        h      = 1'b0;
        c      = 1'b0;
        z_calc = 1'b1;
        wr     = 4'b1111;
        f      = req.flags_in;

        unique case (req.cmd)
            ebcalu_pkg::OP_ADD, ebcalu_pkg::OP_ADC: begin
                r8 = add8[7:0];
                h  = add4[4];
                c  = add8[8];
            end
            ebcalu_pkg::OP_SUB, ebcalu_pkg::OP_SBC: begin
                r8 = sub8[7:0];
                n  = 1'b1;
                h  = sub4[4];
                c  = sub8[8];
            end
            ebcalu_pkg::OP_CP: begin
                r8     = a;
                n      = 1'b1;
                h      = sub4[4];
                c      = sub8[8];
                z      = (a == v);
                z_calc = 1'b0;
            end
            ebcalu_pkg::OP_AND: begin
                r8 = a & v;
                h  = 1'b1;
            end
            ebcalu_pkg::OP_XOR: r8 = a ^ v;
            ebcalu_pkg::OP_OR:  r8 = a | v;
            ebcalu_pkg::OP_INC: begin
                r8 = a + 8'd1;
                h  = (a[3:0] == 4'hF);
                wr = 4'b1110;
            end
            ebcalu_pkg::OP_DEC: begin
                r8 = a - 8'd1;
                n  = 1'b1;
                h  = (a[3:0] == 4'h0);
                wr = 4'b1110;
            end
            ebcalu_pkg::OP_CPL: begin
                r8 = ~a;
                n  = 1'b1;
                h  = 1'b1;
                wr = 4'b0110;
            end
            ebcalu_pkg::OP_RLC, ebcalu_pkg::OP_RLCA: begin
                r8 = {a[6:0], a[7]};
                c  = a[7];
            end
            ebcalu_pkg::OP_RRC, ebcalu_pkg::OP_RRCA: begin
                r8 = {a[0], a[7:1]};
                c  = a[0];
            end
            ebcalu_pkg::OP_RL, ebcalu_pkg::OP_RLA: begin
                r8 = {a[6:0], cin};
                c  = a[7];
            end
            ebcalu_pkg::OP_RR, ebcalu_pkg::OP_RRA: begin
                r8 = {cin, a[7:1]};
                c  = a[0];
            end
            ebcalu_pkg::OP_SLA: begin
                r8 = {a[6:0], 1'b0};
                c  = a[7];
            end
            ebcalu_pkg::OP_SRA: begin
                r8 = {a[7], a[7:1]};
                c  = a[0];
            end
            ebcalu_pkg::OP_SRL: begin
                r8 = {1'b0, a[7:1]};
                c  = a[0];
            end
            ebcalu_pkg::OP_BIT: begin
                r8     = a;
                z      = ~a[req.bit_index];
                z_calc = 1'b0;
                h      = 1'b1;
                wr     = 4'b1110;
            end
            ebcalu_pkg::OP_RES: begin
                r8 = a & ~(8'd1 << req.bit_index);
                wr = 4'b0000;
            end
            ebcalu_pkg::OP_SET: begin
                r8 = a | (8'd1 << req.bit_index);
                wr = 4'b0000;
            end
            default: ;
        endcase

        // 16-bit and unused codes carry the full width
        priority if (req.cmd == ebcalu_pkg::OP_ADD16) begin
            r  = add16[15:0];
            h  = add12[12];
            c  = add16[16];
            wr = 4'b0111;
        end else if (req.cmd == ebcalu_pkg::OP_ADDSP) begin
            r      = sp_sum;
            h      = sp_c4[4];
            c      = sp_c8[8];
            z      = 1'b0;
            z_calc = 1'b0;
        end else if (req.cmd > ebcalu_pkg::OP_ADDSP) begin
            r  = req.target_value;
            wr = 4'b0000;
        end else begin
            r = {8'd0, r8};
        end

        if (z_calc) begin
            z = (r == 16'd0);
        end
        // accumulator rotates always clear Z
        if (req.cmd >= ebcalu_pkg::OP_RLCA && req.cmd <= ebcalu_pkg::OP_RRA) begin
            z = 1'b0;
        end

        if (wr[3]) f[ebcalu_pkg::FLAG_Z] = z;
        if (wr[2]) f[ebcalu_pkg::FLAG_N] = n;
        if (wr[1]) f[ebcalu_pkg::FLAG_H] = h;
        if (wr[0]) f[ebcalu_pkg::FLAG_C] = c;

        rsp.result    = r;
        rsp.flags_out = f;
    end

endmodule

// File: src/ebcalu_checker.sv
// Port-level checker for the ALU top level, with its bind.
`include "eight_bit_cpu_alu_with_flags_top_assert.svh"

module ebcalu_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input ebcalu_pkg::alu_req_t s_req,
    input logic                 m_valid,
    input logic                 m_ready,
    input ebcalu_pkg::alu_rsp_t m_rsp
);

    // a stalled result keeps its payload
    `EBCALU_ASSERT_NEXT(a_rsp_hold, m_valid && !m_ready, m_valid && $stable(m_rsp), "result changed while stalled")

    // with the result register empty, the pipeline always takes a request
    `EBCALU_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready, "s_ready low with empty output")

    // a fresh result comes from a request that passed through the input register
    `EBCALU_ASSERT_NOW(a_no_phantom, $rose(m_valid), $past(s_valid && s_ready, 2), "result without request")

    // low flag nibble passes straight through
    `EBCALU_ASSERT_NOW(a_low_flags, $rose(m_valid), m_rsp.flags_out[3:0] == $past(s_req.flags_in[3:0], 2), "low flag bits altered")

endmodule

bind eight_bit_cpu_alu_with_flags_top ebcalu_checker u_ebcalu_checker (.*);
